>>> rtl/lsra_pkg.sv
// Package for the linear scan register allocator.
// Holds field widths and default sizes; used by linear_scan_register_allocator_top.

package lsra_pkg;

   // default pool size and program point width
   localparam int PoolSizeDefault  = 28;
   localparam int PointBitsDefault = 16;

   // fixed field widths
   localparam int VregBits = 16;
   localparam int PhysBits = 5;

   // result word: granted, phys_reg, failed, virtual_reg_out, padded to bytes
   localparam int RspFieldBits = 1 + PhysBits + 1 + VregBits;
   localparam int RspDataBits  = ((RspFieldBits + 7) / 8) * 8;

   // bit positions inside the result word
   localparam int RspGrantedPos = 0;
   localparam int RspPhysPos    = 1;
   localparam int RspFailedPos  = RspPhysPos + PhysBits;
   localparam int RspVregPos    = RspFailedPos + 1;

endpackage

>>> rtl/linear_scan_register_allocator_top.sv
// Linear scan register allocator, top level.
// Depends on lsra_pkg for widths and default sizes.
//
// Takes one live interval per word and grants the lowest numbered free register of a
// pool of POOL_SIZE, after freeing every busy register whose end point lies strictly
// below the new start point. Intervals must arrive sorted by start point; this is not
// checked. When no register is free the run fails, and every later word of that run
// gives granted=0, failed=1 until a word with first_of_run set clears the pool. The
// block sustains one word per clock cycle when the result side does not stall. The word
// passes an input register; then all stored end points are compared in parallel against
// the start point, the lowest free register is picked and the busy marks are updated,
// feeding the result register. No clearing pass is needed after reset.

module linear_scan_register_allocator_top
   import lsra_pkg::*;
#(
   parameter int POOL_SIZE  = PoolSizeDefault,
   parameter int POINT_BITS = PointBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   // interval words
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // tdata from bit 0: start_point, end_point, virtual_reg, zero padding
   input  logic [((2 * POINT_BITS + VregBits + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: first_of_run
   input  logic                    req_tuser,
   // result words
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // tdata from bit 0: granted, phys_reg[4:0], failed, virtual_reg_out[15:0], zero padding
   output logic [RspDataBits-1:0]  rsp_tdata
);

   localparam int SlotBits = $clog2(POOL_SIZE + 1);

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic                  in_first_ff;
   logic [POINT_BITS-1:0] in_start_ff;
   logic [POINT_BITS-1:0] in_end_ff;
   logic [VregBits-1:0]   in_vreg_ff;

   // allocator state
   logic [POOL_SIZE-1:0]  busy_ff, busy_in;
   logic [POINT_BITS-1:0] end_ff [POOL_SIZE];
   logic                  failed_ff, failed_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RspDataBits-1:0] rsp_data_ff, rsp_data_in;

   // allocation logic
   logic                  out_free;
   logic                  fire;
   logic                  req_take;
   logic [POOL_SIZE-1:0]  busy_base;
   logic                  failed_base;
   logic [POOL_SIZE-1:0]  expired;
   logic [POOL_SIZE-1:0]  busy_left;
   logic [POOL_SIZE-1:0]  free_vec;
   logic [POOL_SIZE-1:0]  grant;
   logic                  any_free;
   logic [SlotBits-1:0]   slot;
   logic                  granted;
   logic [PhysBits-1:0]   phys;

   // handshake: the result register parts the two sides
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // hold or refill the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_first_ff <= req_tuser;
         in_start_ff <= req_tdata[POINT_BITS-1:0];
         in_end_ff   <= req_tdata[2*POINT_BITS-1:POINT_BITS];
         in_vreg_ff  <= req_tdata[2*POINT_BITS +: VregBits];
      end
   end

   // start of a run drops all busy marks and the failure
   assign busy_base   = in_first_ff ? '0 : busy_ff;
   assign failed_base = in_first_ff ? 1'b0 : failed_ff;

   // free expired registers, compared in parallel
   always_comb begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         expired[i] = end_ff[i] < in_start_ff;
      end
   end

   assign busy_left = busy_base & ~expired;
   assign free_vec  = ~busy_left;
   assign any_free  = |free_vec;
   // isolate the lowest free register
   assign grant     = free_vec & (~free_vec + POOL_SIZE'(1));

   // encode the granted register
   always_comb begin
      slot = '0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (grant[i]) begin
            slot = slot | SlotBits'(i);
         end
      end
   end

   assign granted = !failed_base && any_free;
   assign phys    = granted ? PhysBits'(slot + 1'b1) : '0;

   // next state of the pool
   always_comb begin
      busy_in   = busy_ff;
      failed_in = failed_ff;
      if (fire) begin
         if (failed_base) begin
            busy_in   = busy_base;
            failed_in = 1'b1;
         end else begin
            busy_in   = busy_left | grant;
            failed_in = !any_free;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= '0;
         failed_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         failed_ff <= failed_in;
      end
   end

   // keep the end point of the granted register
   always_ff @(posedge clock) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (fire && granted && grant[i]) begin
            end_ff[i] <= in_end_ff;
         end
      end
   end

   // build the result word
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RspGrantedPos]             = granted;
      rsp_data_in[RspPhysPos +: PhysBits]    = phys;
      rsp_data_in[RspFailedPos]              = failed_base || !any_free;
      rsp_data_in[RspVregPos +: VregBits]    = in_vreg_ff;
   end

   // hold or advance the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> test/linear_scan_register_allocator_top_tb.sv
// Testbench for linear_scan_register_allocator_top: streams live intervals and checks
// every result word against a built-in allocation predictor.
// Depends on lsra_pkg and the top level only.
`timescale 1ns / 100ps

module linear_scan_register_allocator_top_tb;
   import lsra_pkg::*;

   localparam int ReqDataBits = ((2 * PointBitsDefault + VregBits + 7) / 8) * 8;
   localparam int PoolRegs    = PoolSizeDefault;
   localparam int RandomWords = 1400;

   // one live interval as the sender sees it; hold_for_drain stalls it until idle
   typedef struct packed {
      logic                    first;
      logic [15:0]             start_pt;
      logic [15:0]             end_pt;
      logic [VregBits-1:0]     vreg;
      logic                    hold_for_drain;
   } interval_type;

   // one allocation outcome
   typedef struct packed {
      logic                    granted;
      logic [PhysBits-1:0]     phys;
      logic                    failed;
      logic [VregBits-1:0]     vreg;
   } grant_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // tdata from bit 0: start_point, end_point, virtual_reg
   logic [ReqDataBits-1:0] req_tdata = '0;
   // tuser: first_of_run
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // tdata from bit 0: granted, phys_reg, failed, virtual_reg_out, zero padding
   logic [RspDataBits-1:0] rsp_tdata;

   interval_type pending_q[$];
   grant_type    expected_q[$];
   logic         word_sent = 1'b0;
   int           words_in = 0;
   int           mismatches = 0;
   logic         gaps_on;

   // allocator shadow state
   logic        pool_busy [PoolRegs];
   logic [15:0] pool_end [PoolRegs];
   logic        pool_exhausted;

   linear_scan_register_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // no idling while the middle stretch of words goes through
   assign gaps_on = !(words_in >= 500 && words_in < 800);

   // free expired registers, then grant the lowest free one or mark the run as failed
   function automatic grant_type allocate_interval(input logic first,
                                                   input logic [15:0] start_pt,
                                                   input logic [15:0] end_pt,
                                                   input logic [VregBits-1:0] vreg);
      grant_type g;
      int        slot;
      g      = '0;
      g.vreg = vreg;
      slot   = -1;
      if (first) begin
         for (int i = 0; i < PoolRegs; i++) pool_busy[i] = 1'b0;
         pool_exhausted = 1'b0;
      end
      if (!pool_exhausted) begin
         for (int i = 0; i < PoolRegs; i++) begin
            if (pool_busy[i] && pool_end[i] < start_pt) pool_busy[i] = 1'b0;
         end
         for (int i = 0; i < PoolRegs; i++) begin
            if (!pool_busy[i] && slot < 0) slot = i;
         end
         if (slot >= 0) begin
            pool_busy[slot] = 1'b1;
            pool_end[slot]  = end_pt;
            g.granted       = 1'b1;
            g.phys          = PhysBits'(slot + 1);
         end else begin
            pool_exhausted = 1'b1;
         end
      end
      g.failed = pool_exhausted;
      return g;
   endfunction

   task automatic report_mismatch(input string what, input grant_type want,
                                  input grant_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected granted=%0d phys=%0d failed=%0d vreg=%h, ",
                  $realtime, what, want.granted, want.phys, want.failed, want.vreg,
                  "got granted=%0d phys=%0d failed=%0d vreg=%h",
                  got.granted, got.phys, got.failed, got.vreg);
   endtask

   task automatic queue_interval(input logic first, input int start_pt, input int end_pt,
                                 input int vreg, input logic hold_for_drain);
      interval_type iv;
      iv.first          = first;
      iv.start_pt       = 16'(start_pt);
      iv.end_pt         = 16'(end_pt);
      iv.vreg           = VregBits'(vreg);
      iv.hold_for_drain = hold_for_drain;
      pending_q = {pending_q, iv};
   endtask

   // driver: offer the next interval once the current word has gone
   always @(negedge clock) begin : drive_intervals
      interval_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || word_sent) begin
         if (pending_q.size() != 0 && !(pending_q[0].hold_for_drain && expected_q.size() != 0)
             && !(gaps_on && $urandom_range(0, 99) < 34)) begin
            nxt = pending_q.pop_front();
            req_tdata  <= ReqDataBits'({nxt.vreg, nxt.end_pt, nxt.start_pt});
            req_tuser  <= nxt.first;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stalls at random outside the calm stretch
   always @(negedge clock) begin
      rsp_tready <= !gaps_on || ($urandom_range(0, 99) >= 34);
   end

   // monitor: check the oldest expectation first, then predict for the word just taken
   always @(posedge clock) begin : watch_results
      grant_type got;
      grant_type want;
      grant_type pred;
      if (reset) begin
         for (int i = 0; i < PoolRegs; i++) begin
            pool_busy[i] = 1'b0;
            pool_end[i]  = '0;
         end
         pool_exhausted = 1'b0;
         word_sent <= 1'b0;
      end else begin
         word_sent <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.granted = rsp_tdata[RspGrantedPos];
            got.phys    = rsp_tdata[RspPhysPos +: PhysBits];
            got.failed  = rsp_tdata[RspFailedPos];
            got.vreg    = rsp_tdata[RspVregPos +: VregBits];
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result word", '0, got);
            end else begin
               want = expected_q.pop_front();
               if (got.granted !== want.granted || got.phys !== want.phys ||
                   got.failed !== want.failed || got.vreg !== want.vreg)
                  report_mismatch("result mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            pred = allocate_interval(req_tuser, req_tdata[15:0], req_tdata[31:16],
                                     req_tdata[32 +: VregBits]);
            expected_q = {expected_q, pred};
            words_in <= words_in + 1;
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int n;
      int kind;
      int cnt;
      int len;
      int pt;
      int step;
      int span;
      int s;
      int e;
      logic fresh;

      // extremes and simple reuse
      queue_interval(1'b1, 0, 0, 0, 1'b0);
      queue_interval(1'b0, 0, 65535, 65535, 1'b0);
      queue_interval(1'b0, 1, 5, 'h5555, 1'b0);
      // end below start, then freed by the next later start
      queue_interval(1'b0, 10, 3, 'haaaa, 1'b0);
      queue_interval(1'b0, 4, 20, 1, 1'b0);
      // unsorted start point
      queue_interval(1'b0, 2, 9, 2, 1'b0);
      // top start point frees all but the register holding the top end point
      queue_interval(1'b0, 65535, 65535, 3, 1'b0);
      // fill the pool, fail, stay failed, then recover on a new run after draining
      for (int i = 0; i < PoolRegs; i++) queue_interval(i == 0, 100, 200, 'h100 + i, 1'b0);
      queue_interval(1'b0, 100, 300, 'hf00d, 1'b0);
      queue_interval(1'b0, 300, 400, 'hbeef, 1'b0);
      queue_interval(1'b1, 50, 60, 'h1234, 1'b1);

      // random part: mostly sorted runs, some noise and broken order
      n = 0;
      while (n < RandomWords) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            cnt = $urandom_range(1, 6);
            repeat (cnt)
               queue_interval(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0);
            n += cnt;
         end else begin
            len   = $urandom_range(1, 60);
            pt    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 4000);
            step  = 1 << $urandom_range(0, 6);
            span  = 1 << $urandom_range(1, 16);
            fresh = ($urandom_range(0, 7) != 0);
            for (int k = 0; k < len; k++) begin
               pt = pt + $urandom_range(0, step);
               if (pt > 65535) pt = 65535;
               s = pt;
               if ($urandom_range(0, 19) == 0) s = $urandom_range(0, 65535);
               e = s + $urandom_range(0, span - 1);
               if (e > 65535) e = 65535;
               if ($urandom_range(0, 29) == 0) e = $urandom_range(0, s);
               queue_interval(k == 0 && fresh, s, e, $urandom_range(0, 65535),
                              k == 0 && $urandom_range(0, 15) == 0);
            end
            n += len;
         end
      end

      // hold reset, then release it on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every word to be taken and every result to arrive
      while (pending_q.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin : watchdog
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/lsra_pkg.sv
rtl/linear_scan_register_allocator_top.sv
test/linear_scan_register_allocator_top_tb.sv
